### src/sie_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment intersection package
// Widths, types and register codes shared by the engine, its cells and the
// channel interfaces.
// ----------------------------------------------------------------------------
package sie_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int THR_WIDTH   = 11;
	localparam int THR_SCALE   = 1000000;
	localparam int TW          = THR_WIDTH + 20;          // threshold times one million
	localparam int DW          = COORD_WIDTH + 1;         // coordinate difference
	localparam int PW          = 2 * DW;                  // product of two differences
	localparam int OW          = PW + 1;                  // orientation and denominator
	localparam int KW          = 2 * COORD_WIDTH + 1;     // line constant
	localparam int PQW         = 2 * OW;                  // product of two orientations
	localparam int MXW         = DW + KW;                 // numerator partial product
	localparam int NW          = MXW + 1;                 // numerator
	localparam int NMW         = NW - 1;                  // numerator magnitude
	localparam int MW          = OW - 1;                  // denominator magnitude
	localparam int SW          = MW + COORD_WIDTH;        // divider remainder
	localparam int ADDR_W      = 3;
	localparam int DATA_W      = 32;

	typedef enum logic [0:0] {
		REG_THR = 1'b0
	} sie_reg_t;

	// Data handed from one divider cell to the next.
	typedef struct packed {
		logic [SW-1:0]          sx;
		logic [SW-1:0]          sy;
		logic [SW-1:0]          dsh;
		logic [COORD_WIDTH-1:0] qx;
		logic [COORD_WIDTH-1:0] qy;
		logic                   negx;
		logic                   negy;
		logic                   ovfx;
		logic                   ovfy;
		logic                   hit;
		logic                   par;
	} sie_cell_t;

endpackage

### src/sie_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment intersection channels
// Request channel carrying two segments and result channel carrying the
// crossing test and the line crossing point.
// ----------------------------------------------------------------------------
interface sie_query_if;
	logic valid;
	logic ready;
	logic signed [sie_pkg::COORD_WIDTH-1:0] ax;
	logic signed [sie_pkg::COORD_WIDTH-1:0] ay;
	logic signed [sie_pkg::COORD_WIDTH-1:0] bx;
	logic signed [sie_pkg::COORD_WIDTH-1:0] by;
	logic signed [sie_pkg::COORD_WIDTH-1:0] cx;
	logic signed [sie_pkg::COORD_WIDTH-1:0] cy;
	logic signed [sie_pkg::COORD_WIDTH-1:0] dx;
	logic signed [sie_pkg::COORD_WIDTH-1:0] dy;
	modport source (output valid, ax, ay, bx, by, cx, cy, dx, dy, input ready);
	modport sink (input valid, ax, ay, bx, by, cx, cy, dx, dy, output ready);
endinterface

interface sie_result_if;
	logic valid;
	logic ready;
	logic intersects;
	logic parallel;
	logic signed [sie_pkg::COORD_WIDTH-1:0] point_x;
	logic signed [sie_pkg::COORD_WIDTH-1:0] point_y;
	modport source (output valid, intersects, parallel, point_x, point_y, input ready);
	modport sink (input valid, intersects, parallel, point_x, point_y, output ready);
endinterface

### src/segment_intersection_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment intersection engine
// Crossing test and line crossing point of two segments, fully pipelined.
// ----------------------------------------------------------------------------
// The engine accepts one request per clock, unless stalled, and returns one
// result per request, in order, after six front-end stages, one divider cell
// per quotient bit, and the output register. A two-entry output buffer lets
// the engine keep taking requests while a result waits; the request side
// stalls only when both entries are full. The threshold register sits at
// byte address 0 and reads back sign-extended.
module segment_intersection_engine_top (
	input  logic clk,
	input  logic arst_n,
	sie_query_if.sink query,
	sie_result_if.source result,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [sie_pkg::ADDR_W-1:0] paddr,
	input  logic [sie_pkg::DATA_W-1:0] pwdata,
	output logic [sie_pkg::DATA_W-1:0] prdata,
	output logic pready
);

	localparam int W = sie_pkg::COORD_WIDTH;

	// Configuration.
	logic signed [sie_pkg::THR_WIDTH-1:0] thr_q;
	logic signed [sie_pkg::TW-1:0] t_q;
	logic reg_hit;

	assign pready  = 1'b1;
	assign reg_hit = paddr[sie_pkg::ADDR_W-1:2] == sie_pkg::REG_THR;
	assign prdata  = reg_hit ? sie_pkg::DATA_W'(thr_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
			t_q   <= '0;
		end else begin
			if (psel && penable && pwrite && reg_hit) begin
				thr_q <= pwdata[sie_pkg::THR_WIDTH-1:0];
			end
			t_q <= sie_pkg::TW'(thr_q) * sie_pkg::TW'(sie_pkg::THR_SCALE);
		end
	end

	// Pipeline.
	logic en;
	logic skid_v_q;
	logic out_v_q;
	logic chain_v [0:W];
	sie_pkg::sie_cell_t chain_c [0:W];

	assign en          = !skid_v_q;
	assign query.ready = en;

	sie_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (query.valid),
		.ax     (query.ax),
		.ay     (query.ay),
		.bx     (query.bx),
		.by     (query.by),
		.cx     (query.cx),
		.cy     (query.cy),
		.dx     (query.dx),
		.dy     (query.dy),
		.thr    (t_q),
		.out_v  (chain_v[0]),
		.out_c  (chain_c[0])
	);

	for (genvar g = 0; g < W; g++) begin : g_cell
		sie_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.in_v   (chain_v[g]),
			.in_c   (chain_c[g]),
			.out_v  (chain_v[g+1]),
			.out_c  (chain_c[g+1])
		);
	end

	// Sign and saturation of the quotients.
	localparam logic [W-1:0] MAG_MAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MAG_MIN = {1'b1, {(W-1){1'b0}}};

	sie_pkg::sie_cell_t fin;
	logic signed [W-1:0] px, py;

	always_comb begin
		fin = chain_c[W];
		if (fin.par) begin
			px = '0;
		end else if (fin.negx) begin
			px = (fin.ovfx || fin.qx > MAG_MIN) ? MAG_MIN : -fin.qx;
		end else begin
			px = (fin.ovfx || fin.qx > MAG_MAX) ? MAG_MAX : fin.qx;
		end
		if (fin.par) begin
			py = '0;
		end else if (fin.negy) begin
			py = (fin.ovfy || fin.qy > MAG_MIN) ? MAG_MIN : -fin.qy;
		end else begin
			py = (fin.ovfy || fin.qy > MAG_MAX) ? MAG_MAX : fin.qy;
		end
	end

	// Output register plus skid entry.
	logic hit_q, par_q, skid_hit_q, skid_par_q;
	logic signed [W-1:0] px_q, py_q, skid_px_q, skid_py_q;
	logic take;

	assign take = out_v_q && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (take) begin
				skid_v_q <= 1'b0;
			end
		end else if (!out_v_q || take) begin
			out_v_q <= chain_v[W];
		end else if (chain_v[W]) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (take) begin
				hit_q <= skid_hit_q;
				par_q <= skid_par_q;
				px_q  <= skid_px_q;
				py_q  <= skid_py_q;
			end
		end else if (!out_v_q || take) begin
			hit_q <= fin.hit;
			par_q <= fin.par;
			px_q  <= px;
			py_q  <= py;
		end else begin
			skid_hit_q <= fin.hit;
			skid_par_q <= fin.par;
			skid_px_q  <= px;
			skid_py_q  <= py;
		end
	end

	assign result.valid      = out_v_q;
	assign result.intersects = hit_q;
	assign result.parallel   = par_q;
	assign result.point_x    = px_q;
	assign result.point_y    = py_q;

endmodule

### src/sie_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment intersection front end
// Six pipeline stages: cross products, orientation tests, threshold compare,
// Cramer numerators and the setup of the divider chain.
// ----------------------------------------------------------------------------
module sie_front (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_v,
	input  logic signed [sie_pkg::COORD_WIDTH-1:0] ax,
	input  logic signed [sie_pkg::COORD_WIDTH-1:0] ay,
	input  logic signed [sie_pkg::COORD_WIDTH-1:0] bx,
	input  logic signed [sie_pkg::COORD_WIDTH-1:0] by,
	input  logic signed [sie_pkg::COORD_WIDTH-1:0] cx,
	input  logic signed [sie_pkg::COORD_WIDTH-1:0] cy,
	input  logic signed [sie_pkg::COORD_WIDTH-1:0] dx,
	input  logic signed [sie_pkg::COORD_WIDTH-1:0] dy,
	input  logic signed [sie_pkg::TW-1:0] thr,
	output logic out_v,
	output sie_pkg::sie_cell_t out_c
);

	localparam int W = sie_pkg::COORD_WIDTH;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	// Stage 1: differences and their products.
	logic signed [sie_pkg::DW-1:0] ea [0:4];
	logic signed [sie_pkg::DW-1:0] eb [0:4];
	logic signed [sie_pkg::DW-1:0] ec [0:4];
	logic signed [sie_pkg::DW-1:0] ed [0:4];
	logic signed [sie_pkg::PW-1:0] pa_s1 [0:4];
	logic signed [sie_pkg::PW-1:0] pb_s1 [0:4];
	logic signed [2*W-1:0] ka_s1 [0:1];
	logic signed [2*W-1:0] kb_s1 [0:1];
	logic signed [sie_pkg::DW-1:0] x21_s1, y21_s1, x43_s1, y43_s1;

	always_comb begin
		ea[0] = sie_pkg::DW'(cy) - sie_pkg::DW'(by);
		eb[0] = sie_pkg::DW'(cx) - sie_pkg::DW'(ax);
		ec[0] = sie_pkg::DW'(cx) - sie_pkg::DW'(bx);
		ed[0] = sie_pkg::DW'(cy) - sie_pkg::DW'(ay);
		ea[1] = sie_pkg::DW'(dy) - sie_pkg::DW'(by);
		eb[1] = sie_pkg::DW'(dx) - sie_pkg::DW'(ax);
		ec[1] = sie_pkg::DW'(dx) - sie_pkg::DW'(bx);
		ed[1] = sie_pkg::DW'(dy) - sie_pkg::DW'(ay);
		ea[2] = sie_pkg::DW'(ay) - sie_pkg::DW'(dy);
		eb[2] = sie_pkg::DW'(ax) - sie_pkg::DW'(cx);
		ec[2] = sie_pkg::DW'(ax) - sie_pkg::DW'(dx);
		ed[2] = sie_pkg::DW'(ay) - sie_pkg::DW'(cy);
		ea[3] = sie_pkg::DW'(by) - sie_pkg::DW'(dy);
		eb[3] = sie_pkg::DW'(bx) - sie_pkg::DW'(cx);
		ec[3] = sie_pkg::DW'(bx) - sie_pkg::DW'(dx);
		ed[3] = sie_pkg::DW'(by) - sie_pkg::DW'(cy);
		ea[4] = sie_pkg::DW'(bx) - sie_pkg::DW'(ax);
		eb[4] = sie_pkg::DW'(dy) - sie_pkg::DW'(cy);
		ec[4] = sie_pkg::DW'(dx) - sie_pkg::DW'(cx);
		ed[4] = sie_pkg::DW'(by) - sie_pkg::DW'(ay);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 5; i++) begin
				pa_s1[i] <= sie_pkg::PW'(ea[i]) * sie_pkg::PW'(eb[i]);
				pb_s1[i] <= sie_pkg::PW'(ec[i]) * sie_pkg::PW'(ed[i]);
			end
			ka_s1[0] <= (2*W)'(dy) * (2*W)'(cx);
			kb_s1[0] <= (2*W)'(cy) * (2*W)'(dx);
			ka_s1[1] <= (2*W)'(by) * (2*W)'(ax);
			kb_s1[1] <= (2*W)'(ay) * (2*W)'(bx);
			x21_s1 <= ea[4];
			y21_s1 <= ed[4];
			x43_s1 <= ec[4];
			y43_s1 <= eb[4];
		end
	end

	// Stage 2: orientations, denominator and line constants.
	logic signed [sie_pkg::OW-1:0] o_s2 [0:3];
	logic signed [sie_pkg::OW-1:0] den_s2;
	logic signed [sie_pkg::KW-1:0] k34_s2, k12_s2;
	logic signed [sie_pkg::DW-1:0] x21_s2, y21_s2, x43_s2, y43_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				o_s2[i] <= sie_pkg::OW'(pa_s1[i]) - sie_pkg::OW'(pb_s1[i]);
			end
			den_s2 <= sie_pkg::OW'(pa_s1[4]) - sie_pkg::OW'(pb_s1[4]);
			k34_s2 <= sie_pkg::KW'(ka_s1[0]) - sie_pkg::KW'(kb_s1[0]);
			k12_s2 <= sie_pkg::KW'(ka_s1[1]) - sie_pkg::KW'(kb_s1[1]);
			x21_s2 <= x21_s1;
			y21_s2 <= y21_s1;
			x43_s2 <= x43_s1;
			y43_s2 <= y43_s1;
		end
	end

	// Stage 3: orientation products and numerator partial products.
	logic signed [sie_pkg::PQW-1:0] p_s3, q_s3;
	logic signed [sie_pkg::MXW-1:0] mx0_s3, mx1_s3, my0_s3, my1_s3;
	logic signed [sie_pkg::OW-1:0] den_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			p_s3   <= sie_pkg::PQW'(o_s2[0]) * sie_pkg::PQW'(o_s2[1]);
			q_s3   <= sie_pkg::PQW'(o_s2[2]) * sie_pkg::PQW'(o_s2[3]);
			mx0_s3 <= sie_pkg::MXW'(x21_s2) * sie_pkg::MXW'(k34_s2);
			mx1_s3 <= sie_pkg::MXW'(x43_s2) * sie_pkg::MXW'(k12_s2);
			my0_s3 <= sie_pkg::MXW'(y21_s2) * sie_pkg::MXW'(k34_s2);
			my1_s3 <= sie_pkg::MXW'(y43_s2) * sie_pkg::MXW'(k12_s2);
			den_s3 <= den_s2;
		end
	end

	// Stage 4: threshold compares and numerators.
	logic signed [sie_pkg::PQW-1:0] t_ext;
	logic lt_p_s4, le_p_s4, lt_q_s4, le_q_s4;
	logic signed [sie_pkg::NW-1:0] nx_s4, ny_s4;
	logic signed [sie_pkg::OW-1:0] den_s4;

	assign t_ext = sie_pkg::PQW'(thr);

	always_ff @(posedge clk) begin
		if (en) begin
			lt_p_s4 <= p_s3 < t_ext;
			le_p_s4 <= p_s3 <= t_ext;
			lt_q_s4 <= q_s3 < t_ext;
			le_q_s4 <= q_s3 <= t_ext;
			nx_s4   <= sie_pkg::NW'(mx0_s3) - sie_pkg::NW'(mx1_s3);
			ny_s4   <= sie_pkg::NW'(my0_s3) - sie_pkg::NW'(my1_s3);
			den_s4  <= den_s3;
		end
	end

	// Stage 5: magnitudes and quotient signs.
	logic hit_s5, par_s5, negx_s5, negy_s5;
	logic [sie_pkg::NMW-1:0] nmx_s5, nmy_s5;
	logic [sie_pkg::MW-1:0] dm_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			// min below threshold and max at most threshold
			hit_s5  <= (lt_p_s4 && le_q_s4) || (lt_q_s4 && le_p_s4);
			par_s5  <= den_s4 == '0;
			negx_s5 <= nx_s4[sie_pkg::NW-1] ^ den_s4[sie_pkg::OW-1];
			negy_s5 <= ny_s4[sie_pkg::NW-1] ^ den_s4[sie_pkg::OW-1];
			nmx_s5  <= sie_pkg::NMW'(nx_s4[sie_pkg::NW-1] ? -nx_s4 : nx_s4);
			nmy_s5  <= sie_pkg::NMW'(ny_s4[sie_pkg::NW-1] ? -ny_s4 : ny_s4);
			dm_s5   <= sie_pkg::MW'(den_s4[sie_pkg::OW-1] ? -den_s4 : den_s4);
		end
	end

	// Stage 6: a quotient that needs more than W bits saturates outright.
	logic [sie_pkg::SW-1:0] dfull;
	sie_pkg::sie_cell_t c_s6;

	assign dfull = {dm_s5, {W{1'b0}}};

	always_ff @(posedge clk) begin
		if (en) begin
			c_s6.sx   <= sie_pkg::SW'(nmx_s5);
			c_s6.sy   <= sie_pkg::SW'(nmy_s5);
			c_s6.dsh  <= sie_pkg::SW'({dm_s5, {(W-1){1'b0}}});
			c_s6.qx   <= '0;
			c_s6.qy   <= '0;
			c_s6.negx <= negx_s5;
			c_s6.negy <= negy_s5;
			c_s6.ovfx <= sie_pkg::SW'(nmx_s5) >= dfull;
			c_s6.ovfy <= sie_pkg::SW'(nmy_s5) >= dfull;
			c_s6.hit  <= hit_s5;
			c_s6.par  <= par_s5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	assign out_v = v_s6;
	assign out_c = c_s6;

endmodule

### src/sie_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment intersection divider cell
// One restoring step for both quotients: compare, subtract, shift, and hand
// the partial remainders on to the next cell.
// ----------------------------------------------------------------------------
module sie_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_v,
	input  sie_pkg::sie_cell_t in_c,
	output logic out_v,
	output sie_pkg::sie_cell_t out_c
);

	localparam int W = sie_pkg::COORD_WIDTH;

	logic gex, gey;
	logic [sie_pkg::SW-1:0] rx, ry;
	sie_pkg::sie_cell_t nxt;
	sie_pkg::sie_cell_t c_q;
	logic v_q;

	always_comb begin
		gex = in_c.sx >= in_c.dsh;
		gey = in_c.sy >= in_c.dsh;
		rx  = gex ? in_c.sx - in_c.dsh : in_c.sx;
		ry  = gey ? in_c.sy - in_c.dsh : in_c.sy;
		nxt    = in_c;
		// The remainder stays below the shifted divisor, so the shift loses nothing.
		nxt.sx = {rx[sie_pkg::SW-2:0], 1'b0};
		nxt.sy = {ry[sie_pkg::SW-2:0], 1'b0};
		nxt.qx = {in_c.qx[W-2:0], gex};
		nxt.qy = {in_c.qy[W-2:0], gey};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= in_v;
		end
	end

	assign out_v = v_q;
	assign out_c = c_q;

endmodule

### src/sie_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment intersection checker
// Port-level assertions on the result channel and the threshold register.
// ----------------------------------------------------------------------------
module sie_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic r_valid,
	input  logic r_ready,
	input  logic r_par,
	input  logic signed [sie_pkg::COORD_WIDTH-1:0] r_px,
	input  logic signed [sie_pkg::COORD_WIDTH-1:0] r_py,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [sie_pkg::ADDR_W-1:0] paddr,
	input  logic [sie_pkg::DATA_W-1:0] pwdata,
	input  logic [sie_pkg::DATA_W-1:0] prdata
);

	localparam int TH = sie_pkg::THR_WIDTH;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |=> r_valid)
		else $error("result dropped while stalled");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |=> $stable(r_px) && $stable(r_py) && $stable(r_par))
		else $error("stalled result changed");

	a_par_zero: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && r_par |-> r_px == '0 && r_py == '0)
		else $error("parallel result carries a nonzero point");

	a_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && paddr[sie_pkg::ADDR_W-1:2] == sie_pkg::REG_THR
		##1 paddr[sie_pkg::ADDR_W-1:2] == sie_pkg::REG_THR
		|-> prdata[TH-1:0] == $past(pwdata[TH-1:0]))
		else $error("threshold readback mismatch");

	a_sext: assert property (@(posedge clk) disable iff (!arst_n)
		paddr[sie_pkg::ADDR_W-1:2] == sie_pkg::REG_THR
		|-> prdata[sie_pkg::DATA_W-1:TH] == {(sie_pkg::DATA_W-TH){prdata[TH-1]}})
		else $error("threshold readback not sign extended");

endmodule

bind segment_intersection_engine_top sie_checker u_sie_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.r_valid (result.valid),
	.r_ready (result.ready),
	.r_par   (result.parallel),
	.r_px    (result.point_x),
	.r_py    (result.point_y),
	.psel    (psel),
	.penable (penable),
	.pwrite  (pwrite),
	.paddr   (paddr),
	.pwdata  (pwdata),
	.prdata  (prdata)
);

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment intersection engine testbench
// Drives segment pairs through the request channel, predicts the crossing
// test and the line crossing point with exact wide arithmetic, and checks
// every result in order while the threshold register is stepped through
// several values, both signs and zero among them.
// ----------------------------------------------------------------------------
module tb;

	localparam int CW = sie_pkg::COORD_WIDTH;
	localparam longint CYCLE_LIMIT = 400000;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [191:0] wide_t;

	typedef struct packed {
		coord_t ax, ay, bx, by, cx, cy, dx, dy;
	} seg_pair_t;

	typedef struct packed {
		logic   intersects;
		logic   parallel;
		coord_t point_x;
		coord_t point_y;
	} crossing_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [sie_pkg::ADDR_W-1:0] paddr;
	logic [sie_pkg::DATA_W-1:0] pwdata, prdata;

	sie_query_if  query ();
	sie_result_if result ();

	segment_intersection_engine_top u_dut (
		.clk(clk), .arst_n(arst_n), .query(query), .result(result),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	crossing_t expected_q[$];
	logic signed [sie_pkg::THR_WIDTH-1:0] threshold;
	int  mismatches;
	int  sent_count;
	longint cycle_count;
	bit  quiet_sender, quiet_receiver;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic wide_t cross_of(wide_t p, wide_t q, wide_t r, wide_t s);
		return p * q - r * s;
	endfunction

	function automatic coord_t clamp_coord(wide_t v);
		wide_t lo, hi;
		lo = -(wide_t'(1) <<< (CW - 1));
		hi = (wide_t'(1) <<< (CW - 1)) - 1;
		if (v < lo) return coord_t'(lo);
		if (v > hi) return coord_t'(hi);
		return coord_t'(v);
	endfunction

	function automatic crossing_t predict_crossing(seg_pair_t s);
		wide_t x1, y1, x2, y2, x3, y3, x4, y4;
		wide_t o1, o2, o3, o4, p, q, t, lo_pq, hi_pq, den, k34, k12, nx, ny;
		crossing_t r;
		x1 = s.ax; y1 = s.ay; x2 = s.bx; y2 = s.by;
		x3 = s.cx; y3 = s.cy; x4 = s.dx; y4 = s.dy;
		o1 = cross_of(y3 - y2, x3 - x1, x3 - x2, y3 - y1);
		o2 = cross_of(y4 - y2, x4 - x1, x4 - x2, y4 - y1);
		o3 = cross_of(y1 - y4, x1 - x3, x1 - x4, y1 - y3);
		o4 = cross_of(y2 - y4, x2 - x3, x2 - x4, y2 - y3);
		p = o1 * o2;
		q = o3 * o4;
		t = wide_t'(threshold) * 1000000;
		lo_pq = (p < q) ? p : q;
		hi_pq = (p < q) ? q : p;
		r.intersects = (lo_pq < t) && (hi_pq <= t);
		den = cross_of(x2 - x1, y4 - y3, x4 - x3, y2 - y1);
		if (den == 0) begin
			r.parallel = 1'b1;
			r.point_x = '0;
			r.point_y = '0;
		end else begin
			k34 = cross_of(y4, x3, y3, x4);
			k12 = cross_of(y2, x1, y1, x2);
			nx = (x2 - x1) * k34 - (x4 - x3) * k12;
			ny = (y2 - y1) * k34 - (y4 - y3) * k12;
			// SystemVerilog signed division truncates toward zero.
			r.parallel = 1'b0;
			r.point_x = clamp_coord(nx / den);
			r.point_y = clamp_coord(ny / den);
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		mismatches++;
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
			cycle_count);
	endtask

	// Result checker with random back-pressure.
	always @(posedge clk) begin
		crossing_t want;
		if (arst_n && result.valid && result.ready) begin
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				want = expected_q.pop_front();
				if (result.intersects !== want.intersects)
					report_mismatch("intersects", result.intersects, want.intersects);
				if (result.parallel !== want.parallel)
					report_mismatch("parallel", result.parallel, want.parallel);
				if (result.point_x !== want.point_x)
					report_mismatch("point_x", result.point_x, want.point_x);
				if (result.point_y !== want.point_y)
					report_mismatch("point_y", result.point_y, want.point_y);
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) result.ready <= 1'b0;
		else result.ready <= quiet_receiver || ($urandom_range(99) >= 12);
	end

	// Starts and ends at a falling edge; valid stays up so that requests
	// can follow each other with no gap.
	task automatic send_pair(seg_pair_t s);
		while (!quiet_sender && $urandom_range(99) < 12) begin
			query.valid <= 1'b0;
			@(negedge clk);
		end
		query.valid <= 1'b1;
		{query.ax, query.ay, query.bx, query.by, query.cx, query.cy, query.dx,
			query.dy} <= s;
		@(posedge clk);
		while (!query.ready) @(posedge clk);
		expected_q.push_back(predict_crossing(s));
		sent_count++;
		@(negedge clk);
	endtask

	task automatic drain_results();
		query.valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (CW + 12) @(posedge clk);
	endtask

	task automatic write_threshold(logic signed [sie_pkg::THR_WIDTH-1:0] value);
		@(negedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= sie_pkg::ADDR_W'(int'(sie_pkg::REG_THR) * 4);
		pwdata <= sie_pkg::DATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		threshold = value;
	endtask

	function automatic coord_t edge_coord();
		case ($urandom_range(3))
			0: return coord_t'(-(1 << (CW - 1)));
			1: return coord_t'((1 << (CW - 1)) - 1);
			2: return coord_t'($urandom_range(7)) - 3;
			default: return coord_t'($urandom);
		endcase
	endfunction

	task automatic test_directed();
		seg_pair_t s;
		coord_t mn, mx;
		mn = coord_t'(-(1 << (CW - 1)));
		mx = coord_t'((1 << (CW - 1)) - 1);
		// Plain crossing: an X through the origin.
		send_pair('{-100, -100, 100, 100, -100, 100, 100, -100});
		// Disjoint parallel lines and collinear overlapping segments.
		send_pair('{0, 0, 100, 0, 0, 10, 100, 10});
		send_pair('{0, 0, 100, 0, 50, 0, 200, 0});
		// Degenerate segments collapsed to points.
		send_pair('{5, 5, 5, 5, 5, 5, 5, 5});
		send_pair('{0, 0, 0, 0, 1, 2, 3, 4});
		// Touching at an end point.
		send_pair('{0, 0, 10, 10, 10, 10, 20, 0});
		// Crossing with a fractional point, truncated toward zero.
		send_pair('{0, 0, 3, 1, 0, 1, 3, -1});
		send_pair('{0, 0, -3, -1, 0, -1, -3, 1});
		// Full-width, nearly flat lines crossing, lines meeting beyond the segments, and parallel pairs.
		send_pair('{mn, 0, mx, 1, mn, 1, mx, 0});
		send_pair('{0, 0, 1, 1, 0, 2, 1, 2});
		send_pair('{0, 0, 1, 1, 0, 2, -1, 2});
		send_pair('{0, 0, 1, 1, 0, -2, -1, -3});
		send_pair('{0, 0, -1, 1, 0, 2, 1, 1});
		// Full-scale corners.
		send_pair('{mn, mn, mx, mx, mn, mx, mx, mn});
		send_pair('{mx, mx, mn, mn, mx, mn, mn, mx});
		send_pair('{mn, mn, mn, mn, mx, mx, mx, mx});
		send_pair('{mx, mn, mn, mx, mx, mx, mn, mn});
		s = '1;
		send_pair(s);
		send_pair('0);
	endtask

	task automatic test_random(int count);
		seg_pair_t s;
		int span;
		for (int i = 0; i < count; i++) begin
			// Short segments near the origin make the threshold test matter.
			case ($urandom_range(3))
				0: begin
					span = $urandom_range(60) + 1;
					s.ax = coord_t'($urandom_range(2 * span) - span);
					s.ay = coord_t'($urandom_range(2 * span) - span);
					s.bx = coord_t'($urandom_range(2 * span) - span);
					s.by = coord_t'($urandom_range(2 * span) - span);
					s.cx = coord_t'($urandom_range(2 * span) - span);
					s.cy = coord_t'($urandom_range(2 * span) - span);
					s.dx = coord_t'($urandom_range(2 * span) - span);
					s.dy = coord_t'($urandom_range(2 * span) - span);
				end
				1: begin
					s = {edge_coord(), edge_coord(), edge_coord(), edge_coord(),
						edge_coord(), edge_coord(), edge_coord(), edge_coord()};
				end
				2: begin
					// Parallel pairs: second segment is the first one shifted.
					s.ax = coord_t'($urandom_range(4000) - 2000);
					s.ay = coord_t'($urandom_range(4000) - 2000);
					s.bx = coord_t'($urandom_range(4000) - 2000);
					s.by = coord_t'($urandom_range(4000) - 2000);
					span = $urandom_range(200) - 100;
					s.cx = coord_t'(s.ax + span); s.dx = coord_t'(s.bx + span);
					span = $urandom_range(200) - 100;
					s.cy = coord_t'(s.ay + span); s.dy = coord_t'(s.by + span);
				end
				default: s = {$urandom, $urandom, $urandom, $urandom};
			endcase
			send_pair(s);
		end
	endtask

	task automatic test_threshold_sweep();
		logic signed [sie_pkg::THR_WIDTH-1:0] settings[5];
		settings = '{-1000, 1000, 1, -1, 0};
		foreach (settings[i]) begin
			drain_results();
			write_threshold(settings[i]);
			test_random(40);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		query.valid = 1'b0;
		{query.ax, query.ay, query.bx, query.by, query.cx, query.cy, query.dx,
			query.dy} = '0;
		result.ready = 1'b0;
		threshold = '0;
		mismatches = 0;
		sent_count = 0;
		cycle_count = 0;
		quiet_sender = 1'b0;
		quiet_receiver = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random(330);
		quiet_sender = 1'b1;
		quiet_receiver = 1'b1;
		test_random(150);
		quiet_sender = 1'b0;
		quiet_receiver = 1'b0;
		test_threshold_sweep();
		drain_results();

		if (mismatches == 0 && expected_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
